/* rtl/aui_pkg.sv */
// shared types and constants for the angle unwrap and iir filter block
package aui_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int FRAC_BITS   = 16;
	localparam int ACC_BITS    = 32;
	localparam int ANGLE_BITS  = 48;
	localparam int ABS_BITS    = 32;
	localparam int MARGIN_BITS = 11;
	localparam int ALPHA_BITS  = 17;
	localparam int CFG_BITS    = 17;
	localparam int INDEX_BITS  = 1;

	localparam logic [1:0] ACT_FILT   = 2'd0;
	localparam logic [1:0] ACT_RAW    = 2'd1;
	localparam logic [1:0] ACT_ZERO   = 2'd2;
	localparam logic [1:0] ACT_STATUS = 2'd3;

	localparam logic [INDEX_BITS-1:0] REG_MARGIN = 1'd0;
	localparam logic [INDEX_BITS-1:0] REG_ALPHA  = 1'd1;

	localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = 11'd20;
	localparam logic [ALPHA_BITS-1:0]  ALPHA_RESET  = 17'd2621;
	localparam logic [ALPHA_BITS-1:0]  ALPHA_ONE    = 17'd65536;

	typedef struct packed {
		logic [1:0]             action;
		logic [SAMPLE_BITS-1:0] sample;
	} aui_req_t;

	typedef struct packed {
		logic signed [ANGLE_BITS-1:0] angle_rel;
		logic signed [ABS_BITS-1:0]   unwrapped_abs;
		logic                         rejected;
		logic                         seeded;
	} aui_res_t;

endpackage

/* rtl/angle_unwrap_iir_filter.sv */
// angle unwrap, multi-turn accumulator and first-order iir low-pass, top level
// an accepted request is held in the input register, its result in the result register
// throughput: one request per cycle while the output is not stalled; the unwrap,
// accumulator and iir update are combinational between the input and result registers
// reset: asynchronous, clears all tracking state and offset, config back to defaults
module angle_unwrap_iir_filter (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  aui_pkg::aui_req_t                      in_req,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output aui_pkg::aui_res_t                      out_res,
	input  logic                                   cfg_we,
	input  logic [aui_pkg::INDEX_BITS-1:0]         cfg_index,
	input  logic [aui_pkg::CFG_BITS-1:0]           cfg_data
);
	import aui_pkg::*;

	localparam int TURN      = 1 << SAMPLE_BITS;
	localparam int HALF_TURN = TURN / 2;
	localparam int DW        = SAMPLE_BITS + 2;
	localparam int DIFF_W    = ANGLE_BITS + 1;
	localparam int PROD_W    = DIFF_W + ALPHA_BITS + 1;
	localparam int STEP_W    = PROD_W - 16;
	localparam int WIDE_W    = STEP_W + 1;

	function automatic logic signed [ANGLE_BITS-1:0] sat_angle(input logic signed [WIDE_W-1:0] v);
		logic hi_same;
		hi_same = (v[WIDE_W-1:ANGLE_BITS-1] == '0) || (v[WIDE_W-1:ANGLE_BITS-1] == '1);
		if (hi_same) begin
			return v[ANGLE_BITS-1:0];
		end else if (v[WIDE_W-1]) begin
			return {1'b1, {(ANGLE_BITS-1){1'b0}}};
		end else begin
			return {1'b0, {(ANGLE_BITS-1){1'b1}}};
		end
	endfunction

	function automatic logic signed [ANGLE_BITS-1:0] rel_of(input logic signed [ANGLE_BITS-1:0] a,
			input logic signed [ANGLE_BITS-1:0] b);
		logic signed [WIDE_W-1:0] d;
		d = WIDE_W'(a) - WIDE_W'(b);
		return sat_angle(d);
	endfunction

	// config registers
	logic [MARGIN_BITS-1:0] margin_q;
	logic [ALPHA_BITS-1:0]  alpha_q;

	// tracking state
	logic [SAMPLE_BITS-1:0]        prev_q;
	logic signed [ACC_BITS-1:0]    acc_q;
	logic signed [ANGLE_BITS-1:0]  filt_q;
	logic signed [ANGLE_BITS-1:0]  offset_q;
	logic                          first_q;

	// pipeline
	logic      valid_s1;
	aui_req_t  req_s1;
	logic      out_valid_q;
	aui_res_t  res_q;
	logic      adv;

	// datapath
	logic [SAMPLE_BITS-1:0]        s;
	logic [SAMPLE_BITS:0]          rail_sum;
	logic                          reject;
	logic [ALPHA_BITS-1:0]         alpha_eff;
	logic signed [DW-1:0]          d_raw;
	logic signed [DW-1:0]          d_wrap;
	logic signed [ACC_BITS:0]      acc_sum;
	logic signed [ACC_BITS-1:0]    acc_step;
	logic signed [ANGLE_BITS-1:0]  x_step;
	logic signed [ANGLE_BITS-1:0]  x_cur;
	logic signed [ANGLE_BITS-1:0]  x_seed;
	logic signed [DIFF_W-1:0]      iir_diff;
	logic signed [PROD_W-1:0]      iir_prod;
	logic signed [PROD_W-1:0]      iir_round;
	logic signed [STEP_W-1:0]      iir_step;
	logic signed [ANGLE_BITS-1:0]  filt_step;

	logic [SAMPLE_BITS-1:0]        prev_d;
	logic signed [ACC_BITS-1:0]    acc_d;
	logic signed [ANGLE_BITS-1:0]  filt_d;
	logic signed [ANGLE_BITS-1:0]  offset_d;
	logic                          first_d;
	aui_res_t                      res_d;

	assign adv       = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !adv;
	assign out_valid = out_valid_q;
	assign out_res   = res_q;

	always_comb begin
		s         = req_s1.sample;
		rail_sum  = {1'b0, s} + {2'b00, margin_q};
		reject    = (s < {1'b0, margin_q}) || (rail_sum > (SAMPLE_BITS+1)'(TURN - 1));
		alpha_eff = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;

		// unwrap against the previous good sample
		d_raw = $signed({2'b00, s}) - $signed({2'b00, prev_q});
		if (d_raw > DW'(HALF_TURN)) begin
			d_wrap = d_raw - DW'(TURN);
		end else if (d_raw < -DW'(HALF_TURN)) begin
			d_wrap = d_raw + DW'(TURN);
		end else begin
			d_wrap = d_raw;
		end
		acc_sum = (ACC_BITS+1)'(acc_q) + (ACC_BITS+1)'(d_wrap);
		if (acc_sum[ACC_BITS] == acc_sum[ACC_BITS-1]) begin
			acc_step = acc_sum[ACC_BITS-1:0];
		end else if (acc_sum[ACC_BITS]) begin
			acc_step = {1'b1, {(ACC_BITS-1){1'b0}}};
		end else begin
			acc_step = {1'b0, {(ACC_BITS-1){1'b1}}};
		end
		x_step = {acc_step, {FRAC_BITS{1'b0}}};
		x_cur  = {acc_q, {FRAC_BITS{1'b0}}};
		x_seed = $signed({{(ANGLE_BITS-SAMPLE_BITS-FRAC_BITS){1'b0}}, s, {FRAC_BITS{1'b0}}});

		// iir step, halves rounded towards +infinity
		iir_diff  = DIFF_W'(x_step) - DIFF_W'(filt_q);
		iir_prod  = PROD_W'(iir_diff) * $signed({1'b0, alpha_eff});
		iir_round = iir_prod + PROD_W'(32768);
		iir_step  = iir_round[PROD_W-1:16];
		filt_step = sat_angle(WIDE_W'(filt_q) + WIDE_W'(iir_step));

		prev_d   = prev_q;
		acc_d    = acc_q;
		filt_d   = filt_q;
		offset_d = offset_q;
		first_d  = first_q;
		res_d.rejected = 1'b0;
		res_d.seeded   = 1'b0;
		res_d.angle_rel = rel_of(x_cur, offset_q);

		case (req_s1.action)
			ACT_ZERO: begin
				offset_d        = filt_q;
				res_d.angle_rel = '0;
			end
			ACT_STATUS: begin
				res_d.angle_rel = rel_of(x_cur, offset_q);
			end
			default: begin
				if (reject) begin
					res_d.rejected = 1'b1;
					if (req_s1.action == ACT_FILT) begin
						res_d.angle_rel = rel_of(filt_q, offset_q);
					end else begin
						res_d.angle_rel = rel_of(x_cur, offset_q);
					end
				end else if (!first_q) begin
					prev_d          = s;
					acc_d           = ACC_BITS'($signed({1'b0, s}));
					filt_d          = x_seed;
					first_d         = 1'b1;
					res_d.seeded    = 1'b1;
					res_d.angle_rel = rel_of(x_seed, offset_q);
				end else begin
					prev_d = s;
					acc_d  = acc_step;
					if (req_s1.action == ACT_FILT) begin
						filt_d          = filt_step;
						res_d.angle_rel = rel_of(filt_step, offset_q);
					end else begin
						res_d.angle_rel = rel_of(x_step, offset_q);
					end
				end
			end
		endcase
		res_d.unwrapped_abs = acc_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= MARGIN_RESET;
			alpha_q  <= ALPHA_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MARGIN: margin_q <= cfg_data[MARGIN_BITS-1:0];
				REG_ALPHA:  alpha_q  <= cfg_data[ALPHA_BITS-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= '0;
			acc_q    <= '0;
			filt_q   <= '0;
			offset_q <= '0;
			first_q  <= 1'b0;
		end else if (adv) begin
			prev_q   <= prev_d;
			acc_q    <= acc_d;
			filt_q   <= filt_d;
			offset_q <= offset_d;
			first_q  <= first_d;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1 <= in_req;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
		end
	end

endmodule
